### rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg - shared definitions for the humidity/temperature frame decoder
// Register map, reset values, byte positions and the CRC-8 step function.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_SENSOR_MODE = 3'd0;
  localparam logic [RegIdxW-1:0] REG_TEMP_GAIN   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_HUMI_GAIN   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TEMP_OFFSET = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HUMI_OFFSET = 3'd4;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register reset values
  localparam logic        MODE_RST        = 1'b0;
  localparam logic [14:0] TEMP_GAIN_RST   = 15'd17500;
  localparam logic [15:0] HUMI_GAIN_RST   = 16'd20000;
  localparam logic [15:0] TEMP_OFFSET_RST = 16'hEE6C;  // -4500
  localparam logic [15:0] HUMI_OFFSET_RST = 16'h0000;

  // Frame byte positions
  localparam logic [2:0] POS_TEMP_HI   = 3'd0;
  localparam logic [2:0] POS_TEMP_LO   = 3'd1;
  localparam logic [2:0] POS_CRC       = 3'd2;
  localparam logic [2:0] POS_LAST_PLN  = 3'd3;
  localparam logic [2:0] POS_LAST_CHK  = 3'd4;
  localparam logic [2:0] POS_IDLE      = 3'd7;

  // CRC-8, polynomial 0x31, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [15:0] TEMP_RAW_BAD = 16'hFFFF;
  localparam logic [13:0] HUMI_MAX     = 14'd9999;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder - sensor byte stream to scaled readings
// Frames sensor bytes, checks the CRC-8 and scales temperature and humidity.
// ----------------------------------------------------------------------------
// Takes one sensor byte per request on the input channel and returns one
// reading per completed frame. A byte with frame_start_i set restarts the
// frame. In checked mode (sensor_mode = 0) a frame is temperature high/low,
// CRC-8 (poly 0x31, init 0xFF, over the temperature bytes), humidity
// high/low; in plain mode (sensor_mode = 1) the CRC byte is absent and
// data_ok_o is always 1. Temperature is ((raw*temp_gain)>>16)+temp_offset
// saturated to 16 bits signed; humidity is ((raw*humi_gain)>>16)+humi_offset
// clamped to 0..9999. Bytes after a frame's end are dropped until the next
// frame start. Rate: one byte per clock cycle while in_stall_o is low; the
// framing state and CRC update in the cycle a byte is taken, and the last
// byte's 16x15 and 16x16 multiplies, offset adds and clamps go straight
// into the result buffer, which registers the reading. A two-entry result
// buffer (output register plus skid register) keeps bytes flowing while a
// reading waits; input stall rises only when both entries hold readings.
// Registers at byte addresses 0x00 mode, 0x04 temp_gain, 0x08 humi_gain,
// 0x0C temp_offset, 0x10 humi_offset; write them only while idle.
`default_nettype none

module humidity_temp_frame_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [htfd_pkg::AddrW-1:0]  paddr,
  input  wire logic [htfd_pkg::DataW-1:0]  pwdata,
  output      logic [htfd_pkg::DataW-1:0]  prdata,
  output      logic                        pready,
  // byte input channel
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic                        frame_start_i,
  // reading output channel
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic signed [15:0]          temperature_o,
  output      logic [13:0]                 humidity_o,
  output      logic                        data_ok_o
);

  import htfd_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        mode_q;
  logic [14:0] temp_gain_q;
  logic [15:0] humi_gain_q;
  logic [15:0] temp_offset_q;
  logic [15:0] humi_offset_q;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_RST;
      temp_gain_q   <= TEMP_GAIN_RST;
      humi_gain_q   <= HUMI_GAIN_RST;
      temp_offset_q <= TEMP_OFFSET_RST;
      humi_offset_q <= HUMI_OFFSET_RST;
    end else if (cfg_wr) begin
      // drop writes beyond the register list
      unique case (cfg_idx)
        REG_SENSOR_MODE: mode_q        <= pwdata[0];
        REG_TEMP_GAIN:   temp_gain_q   <= pwdata[14:0];
        REG_HUMI_GAIN:   humi_gain_q   <= pwdata[15:0];
        REG_TEMP_OFFSET: temp_offset_q <= pwdata[15:0];
        REG_HUMI_OFFSET: humi_offset_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SENSOR_MODE: prdata = {{(DataW-1){1'b0}}, mode_q};
      REG_TEMP_GAIN:   prdata = {{(DataW-15){1'b0}}, temp_gain_q};
      REG_HUMI_GAIN:   prdata = {{(DataW-16){1'b0}}, humi_gain_q};
      REG_TEMP_OFFSET: prdata = {{(DataW-16){1'b0}}, temp_offset_q};
      REG_HUMI_OFFSET: prdata = {{(DataW-16){1'b0}}, humi_offset_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Framing state
  // --------------------------------------------------------------------------
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_raw_q, temp_raw_d;
  logic [7:0]  humi_hi_q, humi_hi_d;
  logic [7:0]  rx_crc_q, rx_crc_d;

  logic        in_acc;
  logic [2:0]  pos_cur;
  logic [7:0]  crc_cur;
  logic [2:0]  pos_last;
  logic        byte_live;
  logic        frame_done;

  assign in_acc   = in_valid_i & ~in_stall_o;
  // a frame start restarts position and CRC, even mid-frame
  assign pos_cur  = frame_start_i ? POS_TEMP_HI : pos_q;
  assign crc_cur  = frame_start_i ? CRC_INIT : crc_q;
  assign pos_last = mode_q ? POS_LAST_PLN : POS_LAST_CHK;
  // positions past the current frame length count as idle
  assign byte_live  = (pos_cur <= pos_last);
  assign frame_done = in_acc & byte_live & (pos_cur == pos_last);

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    temp_raw_d = temp_raw_q;
    humi_hi_d  = humi_hi_q;
    rx_crc_d   = rx_crc_q;
    if (in_acc) begin
      pos_d = pos_cur;
      crc_d = crc_cur;
      if (byte_live) begin
        if (pos_cur == POS_TEMP_HI) begin
          temp_raw_d = {rx_byte_i, 8'h00};
          crc_d      = crc8_byte(crc_cur, rx_byte_i);
        end else if (pos_cur == POS_TEMP_LO) begin
          temp_raw_d = {temp_raw_q[15:8], rx_byte_i};
          crc_d      = crc8_byte(crc_cur, rx_byte_i);
        end else if (!mode_q && pos_cur == POS_CRC) begin
          rx_crc_d = rx_byte_i;
        end else if (pos_cur == pos_last - 3'd1) begin
          humi_hi_d = rx_byte_i;
        end
        pos_d = (pos_cur == pos_last) ? POS_IDLE : pos_cur + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_TEMP_HI;
      crc_q      <= CRC_INIT;
      temp_raw_q <= '0;
      humi_hi_q  <= '0;
      rx_crc_q   <= '0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      temp_raw_q <= temp_raw_d;
      humi_hi_q  <= humi_hi_d;
      rx_crc_q   <= rx_crc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Scaling for the last byte of a frame
  // --------------------------------------------------------------------------
  logic [15:0]        humi_raw;
  logic [30:0]        temp_prod;
  logic [31:0]        humi_prod;
  logic signed [16:0] temp_sum;
  logic signed [17:0] humi_sum;
  logic signed [15:0] temp_res;
  logic [13:0]        humi_res;
  logic               ok_res;

  assign humi_raw  = {humi_hi_q, rx_byte_i};
  assign temp_prod = {15'd0, temp_raw_q} * {16'd0, temp_gain_q};
  assign humi_prod = {16'd0, humi_raw} * {16'd0, humi_gain_q};

  assign temp_sum = $signed({2'b00, temp_prod[30:16]})
                  + $signed({temp_offset_q[15], temp_offset_q});
  assign humi_sum = $signed({2'b00, humi_prod[31:16]})
                  + $signed({{2{humi_offset_q[15]}}, humi_offset_q});

  always_comb begin
    // saturate temperature to 16 bits signed
    if (temp_sum > $signed(17'sd32767)) begin
      temp_res = 16'sh7FFF;
    end else if (temp_sum < -$signed(17'sd32768)) begin
      temp_res = 16'sh8000;
    end else begin
      temp_res = temp_sum[15:0];
    end
    // clamp humidity to 0..9999
    if (humi_sum < $signed(18'sd0)) begin
      humi_res = '0;
    end else if (humi_sum > $signed({4'b0000, HUMI_MAX})) begin
      humi_res = HUMI_MAX;
    end else begin
      humi_res = humi_sum[13:0];
    end
  end

  assign ok_res = mode_q | ((crc_q == rx_crc_q) & (temp_raw_q != TEMP_RAW_BAD));

  // --------------------------------------------------------------------------
  // Result buffer: output register plus skid register
  // --------------------------------------------------------------------------
  logic               out_vld_q, skid_vld_q;
  logic signed [15:0] out_temp_q, skid_temp_q;
  logic [13:0]        out_humi_q, skid_humi_q;
  logic               out_ok_q, skid_ok_q;
  logic               out_take;

  assign out_take   = out_vld_q & ~out_stall_i;
  // hold input while both entries are full
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (frame_done) begin
      if (out_vld_q && !out_take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_temp_q <= skid_temp_q;
        out_humi_q <= skid_humi_q;
        out_ok_q   <= skid_ok_q;
      end
    end else if (frame_done) begin
      if (out_vld_q && !out_take) begin
        skid_temp_q <= temp_res;
        skid_humi_q <= humi_res;
        skid_ok_q   <= ok_res;
      end else begin
        out_temp_q <= temp_res;
        out_humi_q <= humi_res;
        out_ok_q   <= ok_res;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign temperature_o = out_temp_q;
  assign humidity_o    = out_humi_q;
  assign data_ok_o     = out_ok_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != 3'd5) && (pos_q != 3'd6))
    else $error("byte position out of range");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (pos_q == POS_IDLE))
    else $error("frame end did not return to idle");

  a_humi_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_humi_q <= HUMI_MAX))
    else $error("humidity above clamp limit");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_take) |=> (out_vld_q && !skid_vld_q))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire
